/* hw/rtl/env_sensor_compensation_unit_assert.svh */
// Assertion macros for the checker file of the compensation unit.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_IMM(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compensation unit assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compensation unit assertion failed");

`endif

/* hw/rtl/esc_pkg.sv */
// Shared types, constants and helper functions of the compensation unit.
package esc_pkg;

    localparam int FRONT_STAGES = 11;
    localparam int DIV_STAGES   = 32;
    localparam int BACK_STAGES  = 10;
    localparam int LAT          = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    // Ceiling of 2^37 / 100; exact division by 100 for any 32-bit magnitude.
    localparam logic [63:0] RECIP100 = 64'h0000_0000_51EB_851F;
    localparam logic [31:0] HUM_MAX  = 32'd102400;

    typedef enum logic [2:0] {
        CFG_TEMP   = 3'd0,
        CFG_PRES_A = 3'd1,
        CFG_PRES_B = 3'd2,
        CFG_PRES_C = 3'd3,
        CFG_HUM    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_req;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] pressure_pa;
        logic [16:0]        humidity_q10;
        logic               divide_fault;
    } t_res;

    // Calibration words, each already extended to 32 bits.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
        logic [31:0] h1, h2, h3, h4, h5, h6, h7;
    } t_calib;

    // Values that ride along with the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic [15:0] adc_h;
        logic        fault;
        logic        big;
    } t_side;

    function automatic logic [31:0] f_asr(input logic [31:0] x, input int unsigned n);
        f_asr = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] f_mag(input logic [31:0] x);
        f_mag = x[31] ? (32'd0 - x) : x;
    endfunction

    // Magnitude divided by 100 through the reciprocal product.
    function automatic logic [26:0] f_div100(input logic [31:0] mag);
        logic [63:0] prod;
        prod = {32'd0, mag} * RECIP100;
        f_div100 = prod[63:37];
    endfunction

    function automatic logic [31:0] f_sign(input logic [26:0] q, input logic neg);
        f_sign = neg ? (32'd0 - {5'd0, q}) : {5'd0, q};
    endfunction

endpackage

/* hw/rtl/esc_front.sv */
// Temperature path and pressure dividend and divisor preparation.
module esc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  esc_pkg::t_req        i_req,
    input  esc_pkg::t_calib      i_cal,
    output logic                 o_valid,
    output logic [31:0]          o_dividend,
    output logic [31:0]          o_divisor,
    output esc_pkg::t_side       o_side
);
    logic [11:1] r_v;
    logic [31:0] r_a1, r_q1;
    logic [31:0] r_m1, r_m2;
    logic [31:0] r_b3, r_m3;
    logic [31:0] r_fine;
    logic [31:0] r_temp [5:11];
    logic [15:0] r_adch [1:11];
    logic [19:0] r_adcp [1:8];
    logic [31:0] r_pa, r_qa;
    logic [31:0] r_qq, r_m5, r_m2a;
    logic [31:0] r_x1, r_x2, r_m5b, r_m2b;
    logic [31:0] r_b8, r_a8;
    logic [31:0] r_dprod, r_pc0;
    logic [31:0] r_div, r_pcm;
    logic [31:0] r_dvd, r_den;
    logic        r_fault, r_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[10:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // Temperature.
        r_a1 <= {15'd0, i_req.raw_temperature[19:3]} - (i_cal.t1 << 1);
        r_q1 <= esc_pkg::f_asr({15'd0, i_req.raw_temperature[19:3]} - (i_cal.t1 << 1), 1);
        r_adch[1] <= i_req.raw_humidity;
        r_adcp[1] <= i_req.raw_pressure;
        r_m1 <= r_a1 * i_cal.t2;
        r_m2 <= r_q1 * r_q1;
        r_b3 <= esc_pkg::f_asr(r_m1, 11);
        r_m3 <= esc_pkg::f_asr(r_m2, 12) * (i_cal.t3 << 4);
        r_fine <= r_b3 + esc_pkg::f_asr(r_m3, 14);
        r_temp[5] <= esc_pkg::f_asr((r_fine << 2) + r_fine + 32'd128, 8);
        r_pa <= esc_pkg::f_asr(r_fine, 1) - 32'd64000;
        r_qa <= esc_pkg::f_asr(esc_pkg::f_asr(r_fine, 1) - 32'd64000, 2);
        // Pressure products.
        r_qq  <= r_qa * r_qa;
        r_m5  <= r_pa * i_cal.p5;
        r_m2a <= i_cal.p2 * r_pa;
        r_x1  <= esc_pkg::f_asr(r_qq, 11) * i_cal.p6;
        r_x2  <= esc_pkg::f_asr(r_qq, 13) * (i_cal.p3 << 5);
        r_m5b <= r_m5;
        r_m2b <= r_m2a;
        r_b8 <= esc_pkg::f_asr(esc_pkg::f_asr(r_x1, 2) + (r_m5b << 1), 2) + (i_cal.p4 << 16);
        r_a8 <= esc_pkg::f_asr(esc_pkg::f_asr(r_x2, 3) + esc_pkg::f_asr(r_m2b, 1), 18);
        r_dprod <= (32'd32768 + r_a8) * i_cal.p1;
        r_pc0 <= (32'd1048576 - {12'd0, r_adcp[8]}) - esc_pkg::f_asr(r_b8, 12);
        r_div <= esc_pkg::f_asr(r_dprod, 15);
        r_pcm <= r_pc0 * 32'd3125;
        // A dividend at or above 2^31 is divided first and doubled afterwards.
        r_fault <= (r_div == 32'd0);
        r_big   <= r_pcm[31];
        r_dvd   <= r_pcm[31] ? r_pcm : (r_pcm << 1);
        r_den   <= r_div;
        for (int i = 2; i <= 11; i++) begin
            r_adch[i] <= r_adch[i-1];
        end
        for (int i = 2; i <= 8; i++) begin
            r_adcp[i] <= r_adcp[i-1];
        end
        for (int i = 6; i <= 11; i++) begin
            r_temp[i] <= r_temp[i-1];
        end
    end

    assign o_valid      = r_v[11];
    assign o_dividend   = r_dvd;
    assign o_divisor    = r_den;
    assign o_side.temp  = r_temp[11];
    assign o_side.adc_h = r_adch[11];
    assign o_side.fault = r_fault;
    assign o_side.big   = r_big;
endmodule

/* hw/rtl/esc_div.sv */
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
module esc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_dividend,
    input  logic [31:0]          i_divisor,
    input  esc_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic [31:0]          o_quotient,
    output esc_pkg::t_side       o_side
);
    localparam int N = esc_pkg::DIV_STAGES;

    logic [N-1:0]   r_v;
    logic [31:0]    r_rem  [N];
    logic [31:0]    r_dvd  [N];
    logic [31:0]    r_quo  [N];
    logic [31:0]    r_den  [N];
    esc_pkg::t_side r_side [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] t;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                t = {32'd0, i_dividend[31]};
                r_dvd[i]  <= i_dividend << 1;
                r_den[i]  <= i_divisor;
                r_side[i] <= i_side;
                if (t >= {1'b0, i_divisor}) begin
                    r_rem[i] <= 32'(t - {1'b0, i_divisor});
                    r_quo[i] <= 32'd1;
                end else begin
                    r_rem[i] <= t[31:0];
                    r_quo[i] <= 32'd0;
                end
            end else begin
                t = {r_rem[i-1], r_dvd[i-1][31]};
                r_dvd[i]  <= r_dvd[i-1] << 1;
                r_den[i]  <= r_den[i-1];
                r_side[i] <= r_side[i-1];
                if (t >= {1'b0, r_den[i-1]}) begin
                    r_rem[i] <= 32'(t - {1'b0, r_den[i-1]});
                    r_quo[i] <= {r_quo[i-1][30:0], 1'b1};
                end else begin
                    r_rem[i] <= t[31:0];
                    r_quo[i] <= {r_quo[i-1][30:0], 1'b0};
                end
            end
        end
    end

    assign o_valid    = r_v[N-1];
    assign o_quotient = r_quo[N-1];
    assign o_side     = r_side[N-1];
endmodule

/* hw/rtl/esc_back.sv */
// Pressure correction after the division and the humidity path.
module esc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_quotient,
    input  esc_pkg::t_side       i_side,
    input  esc_pkg::t_calib      i_cal,
    output logic                 o_valid,
    output esc_pkg::t_res        o_res
);
    localparam int N = esc_pkg::BACK_STAGES;

    logic [N:1]  r_v;
    logic [31:0] r_tmp [1:N];
    logic        r_flt [1:N];
    logic [31:0] r_pc  [1:N];
    // Pressure correction.
    logic [31:0] r_mq, r_m8, r_s8, r_q8;
    logic [31:0] r_ma, r_pb, r_s8b;
    logic [31:0] r_pa3, r_c1, r_pb3;
    // Humidity.
    logic [31:0] r_ts [1:2];
    logic [15:0] r_ah [1:3];
    logic [31:0] r_m3, r_m4, r_m5, r_m7;
    logic [26:0] r_q3, r_q4, r_q5, r_q7;
    logic        r_n3, r_n4, r_n5, r_n7;
    logic [31:0] r_d3, r_d4, r_d7, r_m55;
    logic [26:0] r_q55;
    logic        r_n55;
    logic [31:0] r_d4b, r_v1, r_v4;
    logic [31:0] r_v2p, r_v1b, r_v4b;
    logic [31:0] r_v3, r_v4c;
    logic [31:0] r_qq, r_v3b, r_v4d;
    logic [31:0] r_v6p, r_v3c;
    logic [31:0] r_s;
    logic [16:0] r_hum;

    logic [31:0] n_pc, n_x55, n_d5, n_hum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[N-1:1], i_valid};
        end
    end

    always_comb begin
        n_pc  = i_side.big ? (i_quotient << 1) : i_quotient;
        n_d5  = esc_pkg::f_sign(r_q5, r_n5);
        n_x55 = esc_pkg::f_asr(r_m55, 6);
        n_hum = esc_pkg::f_asr(r_s, 12);
    end

    always_ff @(posedge i_clk) begin
        r_tmp[1] <= i_side.temp;
        r_flt[1] <= i_side.fault;
        r_pc[1]  <= n_pc;
        for (int i = 2; i <= N; i++) begin
            r_tmp[i] <= r_tmp[i-1];
            r_flt[i] <= r_flt[i-1];
        end
        for (int i = 5; i <= N; i++) begin
            r_pc[i] <= r_pc[i-1];
        end
        // Stage 1.
        r_mq <= esc_pkg::f_asr(n_pc, 3) * esc_pkg::f_asr(n_pc, 3);
        r_m8 <= esc_pkg::f_asr(n_pc, 2) * i_cal.p8;
        r_s8 <= esc_pkg::f_asr(n_pc, 8) * esc_pkg::f_asr(n_pc, 8);
        r_q8 <= esc_pkg::f_asr(n_pc, 8);
        r_ts[1] <= i_side.temp;
        r_ah[1] <= i_side.adc_h;
        r_m3 <= i_side.temp * i_cal.h3;
        r_m4 <= i_side.temp * i_cal.h4;
        r_m5 <= i_side.temp * i_cal.h5;
        r_m7 <= i_side.temp * i_cal.h7;
        // Stage 2.
        r_pc[2] <= r_pc[1];
        r_ma  <= i_cal.p9 * esc_pkg::f_asr(r_mq, 13);
        r_pb  <= esc_pkg::f_asr(r_m8, 13);
        r_s8b <= r_s8 * r_q8;
        r_ts[2] <= r_ts[1];
        r_ah[2] <= r_ah[1];
        r_q3 <= esc_pkg::f_div100(esc_pkg::f_mag(r_m3));
        r_q4 <= esc_pkg::f_div100(esc_pkg::f_mag(r_m4));
        r_q5 <= esc_pkg::f_div100(esc_pkg::f_mag(r_m5));
        r_q7 <= esc_pkg::f_div100(esc_pkg::f_mag(r_m7));
        r_n3 <= r_m3[31];
        r_n4 <= r_m4[31];
        r_n5 <= r_m5[31];
        r_n7 <= r_m7[31];
        // Stage 3.
        r_pc[3] <= r_pc[2];
        r_pa3 <= esc_pkg::f_asr(r_ma, 12);
        r_c1  <= r_s8b * i_cal.p10;
        r_pb3 <= r_pb;
        r_ah[3] <= r_ah[2];
        r_d3  <= esc_pkg::f_sign(r_q3, r_n3);
        r_d4  <= esc_pkg::f_sign(r_q4, r_n4);
        r_d7  <= esc_pkg::f_sign(r_q7, r_n7);
        r_m55 <= r_ts[2] * n_d5;
        // Stage 4: pressure is final here, and zero when the divisor was zero.
        r_pc[4] <= r_flt[3] ? 32'd0 : r_pc[3] + esc_pkg::f_asr(r_pa3 + r_pb3
                   + esc_pkg::f_asr(r_c1, 17) + (i_cal.p7 << 7), 4);
        r_q55 <= esc_pkg::f_div100(esc_pkg::f_mag(n_x55));
        r_n55 <= n_x55[31];
        r_d4b <= r_d4;
        r_v1  <= {16'd0, r_ah[3]} - (i_cal.h1 << 4) - esc_pkg::f_asr(r_d3, 1);
        r_v4  <= esc_pkg::f_asr((i_cal.h6 << 7) + r_d7, 4);
        // Stage 5.
        r_v2p <= i_cal.h2 * (r_d4b + esc_pkg::f_sign(r_q55, r_n55) + 32'd16384);
        r_v1b <= r_v1;
        r_v4b <= r_v4;
        // Stage 6.
        r_v3  <= r_v1b * esc_pkg::f_asr(r_v2p, 10);
        r_v4c <= r_v4b;
        // Stage 7.
        r_qq  <= esc_pkg::f_asr(r_v3, 14) * esc_pkg::f_asr(r_v3, 14);
        r_v3b <= r_v3;
        r_v4d <= r_v4c;
        // Stage 8.
        r_v6p <= r_v4d * esc_pkg::f_asr(r_qq, 10);
        r_v3c <= r_v3b;
        // Stage 9.
        r_s <= esc_pkg::f_asr(r_v3c + esc_pkg::f_asr(r_v6p, 1), 10) * 32'd1000;
        // Stage 10: clamp to the valid humidity range.
        if (n_hum[31]) begin
            r_hum <= 17'd0;
        end else if (n_hum > esc_pkg::HUM_MAX) begin
            r_hum <= esc_pkg::HUM_MAX[16:0];
        end else begin
            r_hum <= n_hum[16:0];
        end
    end

    assign o_valid                 = r_v[N];
    assign o_res.temperature_centi = $signed(r_tmp[N]);
    assign o_res.pressure_pa       = $signed(r_pc[N]);
    assign o_res.humidity_q10      = r_hum;
    assign o_res.divide_fault      = r_flt[N];
endmodule

/* hw/rtl/env_sensor_compensation_unit.sv */
// Top level of the integer temperature, pressure and humidity compensation unit.
//
//  channel   | direction | handshake                 | payload
//  request   | in        | start && !busy            | i_req (t_req)
//  result    | out       | o_valid, one cycle        | o_res (t_res)
//  config    | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A request is taken every cycle while busy is low; each result passes through the 11 front
// stages, 32 divider stages and 10 back stages, the divider resolving one
// quotient bit per stage. Throughput is one request per cycle.
// Reset is synchronous and active low; busy is high only during reset.
// The result side cannot stall, so the pipeline never holds.
module env_sensor_compensation_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  esc_pkg::t_req      i_req,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output esc_pkg::t_res      o_res
);
    logic [39:0] r_temp_cal;
    logic [55:0] r_pres_a;
    logic [47:0] r_pres_b;
    logic [23:0] r_pres_c;
    logic [63:0] r_hum_cal;

    esc_pkg::t_calib cal;
    logic            front_valid, div_valid;
    logic [31:0]     dividend, divisor, quotient;
    esc_pkg::t_side  front_side, div_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_pres_a   <= '0;
            r_pres_b   <= '0;
            r_pres_c   <= '0;
            r_hum_cal  <= '0;
        end else if (i_cfg_we) begin
            unique case (esc_pkg::t_cfg_idx'(i_cfg_idx))
                esc_pkg::CFG_TEMP:   r_temp_cal <= i_cfg_data[39:0];
                esc_pkg::CFG_PRES_A: r_pres_a   <= i_cfg_data[55:0];
                esc_pkg::CFG_PRES_B: r_pres_b   <= i_cfg_data[47:0];
                esc_pkg::CFG_PRES_C: r_pres_c   <= i_cfg_data[23:0];
                esc_pkg::CFG_HUM:    r_hum_cal  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1  = {16'd0, r_temp_cal[15:0]};
        cal.t2  = {{16{r_temp_cal[31]}}, r_temp_cal[31:16]};
        cal.t3  = {{24{r_temp_cal[39]}}, r_temp_cal[39:32]};
        cal.p1  = {16'd0, r_pres_a[15:0]};
        cal.p2  = {{16{r_pres_a[31]}}, r_pres_a[31:16]};
        cal.p3  = {{24{r_pres_a[39]}}, r_pres_a[39:32]};
        cal.p4  = {{16{r_pres_a[55]}}, r_pres_a[55:40]};
        cal.p5  = {{16{r_pres_b[15]}}, r_pres_b[15:0]};
        cal.p6  = {{24{r_pres_b[23]}}, r_pres_b[23:16]};
        cal.p7  = {{24{r_pres_b[31]}}, r_pres_b[31:24]};
        cal.p8  = {{16{r_pres_b[47]}}, r_pres_b[47:32]};
        cal.p9  = {{16{r_pres_c[15]}}, r_pres_c[15:0]};
        cal.p10 = {24'd0, r_pres_c[23:16]};
        cal.h1  = {20'd0, r_hum_cal[11:0]};
        cal.h2  = {20'd0, r_hum_cal[23:12]};
        cal.h3  = {{24{r_hum_cal[31]}}, r_hum_cal[31:24]};
        cal.h4  = {{24{r_hum_cal[39]}}, r_hum_cal[39:32]};
        cal.h5  = {{24{r_hum_cal[47]}}, r_hum_cal[47:40]};
        cal.h6  = {24'd0, r_hum_cal[55:48]};
        cal.h7  = {24'd0, r_hum_cal[63:56]};
    end

    assign busy = !i_rst_n;

    esc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_req      (i_req),
        .i_cal      (cal),
        .o_valid    (front_valid),
        .o_dividend (dividend),
        .o_divisor  (divisor),
        .o_side     (front_side)
    );

    esc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (front_valid),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_side     (front_side),
        .o_valid    (div_valid),
        .o_quotient (quotient),
        .o_side     (div_side)
    );

    esc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_valid),
        .i_quotient (quotient),
        .i_side     (div_side),
        .i_cal      (cal),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );
endmodule

/* hw/rtl/esc_checker.sv */
// Port-level checker for the compensation unit, bound to the top level.
`include "env_sensor_compensation_unit_assert.svh"

module esc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input esc_pkg::t_res o_res
);
    // Every result traces back to exactly one request a fixed latency earlier.
    `ESC_ASSERT_IMM(a_no_spurious, i_clk, i_rst_n, o_valid, $past(start && !busy, esc_pkg::LAT))
    `ESC_ASSERT_NEXT(a_no_loss, i_clk, i_rst_n, start && !busy, ##(esc_pkg::LAT - 1) o_valid)
    `ESC_ASSERT_IMM(a_fault_zero, i_clk, i_rst_n, o_valid && o_res.divide_fault, o_res.pressure_pa == 32'sd0)
    `ESC_ASSERT_IMM(a_hum_range, i_clk, i_rst_n, o_valid, o_res.humidity_q10 <= 17'd102400)
endmodule

bind env_sensor_compensation_unit esc_checker u_esc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

/* verif/tb_env_sensor_compensation_unit.sv */
// Self-checking testbench for the environmental sensor compensation unit.
`timescale 1ns / 100ps

module tb_env_sensor_compensation_unit;

    // Compensation predictor and expected-result store.
    class compensation_scoreboard;
        logic [63:0]   calib [5];
        esc_pkg::t_res pending [$];
        int            mismatches;

        function new();
            foreach (calib[i]) calib[i] = '0;
            mismatches = 0;
        endfunction

        function void write_calib(esc_pkg::t_cfg_idx idx, logic [63:0] data);
            case (idx)
                esc_pkg::CFG_TEMP:   calib[idx] = data & 64'hFF_FFFF_FFFF;
                esc_pkg::CFG_PRES_A: calib[idx] = data & 64'hFF_FFFF_FFFF_FFFF;
                esc_pkg::CFG_PRES_B: calib[idx] = data & 64'hFFFF_FFFF_FFFF;
                esc_pkg::CFG_PRES_C: calib[idx] = data & 64'hFF_FFFF;
                default:             calib[idx] = data;
            endcase
        endfunction

        function logic [31:0] sra(logic [31:0] x, int n);
            return $unsigned($signed(x) >>> n);
        endfunction

        function logic [31:0] sfld(logic [63:0] v, int lo, int bits);
            logic [63:0] s;
            s = v >> lo;
            s = s << (64 - bits);
            return 32'($signed(s) >>> (64 - bits));
        endfunction

        function logic [31:0] ufld(logic [63:0] v, int lo, int bits);
            logic [63:0] s;
            s = v >> lo;
            s = s << (64 - bits);
            return 32'(s >> (64 - bits));
        endfunction

        function logic [31:0] div100(logic [31:0] x);
            logic [31:0] m;
            m = x[31] ? -x : x;
            m = m / 100;
            return x[31] ? -m : m;
        endfunction

        function esc_pkg::t_res compensate(esc_pkg::t_req r);
            logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
            logic [31:0] h1, h2, h3, h4, h5, h6, h7;
            logic [31:0] a, b, c, q, fine, temp, pc, dv, v1, v2, v3, v4, v5, v6, hum;
            esc_pkg::t_res res;
            t1 = ufld(calib[0], 0, 16);  t2 = sfld(calib[0], 16, 16);
            t3 = sfld(calib[0], 32, 8);
            p1 = ufld(calib[1], 0, 16);  p2 = sfld(calib[1], 16, 16);
            p3 = sfld(calib[1], 32, 8);  p4 = sfld(calib[1], 40, 16);
            p5 = sfld(calib[2], 0, 16);  p6 = sfld(calib[2], 16, 8);
            p7 = sfld(calib[2], 24, 8);  p8 = sfld(calib[2], 32, 16);
            p9 = sfld(calib[3], 0, 16);  p10 = ufld(calib[3], 16, 8);
            h1 = ufld(calib[4], 0, 12);  h2 = ufld(calib[4], 12, 12);
            h3 = sfld(calib[4], 24, 8);  h4 = sfld(calib[4], 32, 8);
            h5 = sfld(calib[4], 40, 8);  h6 = ufld(calib[4], 48, 8);
            h7 = ufld(calib[4], 56, 8);
            res.divide_fault = 1'b0;

            a = (32'(r.raw_temperature) >> 3) - (t1 << 1);
            b = sra(a * t2, 11);
            q = sra(a, 1);
            c = sra(sra(q * q, 12) * (t3 << 4), 14);
            fine = b + c;
            temp = sra(fine * 5 + 128, 8);

            a = sra(fine, 1) - 32'd64000;
            q = sra(a, 2);
            b = sra(sra(q * q, 11) * p6, 2);
            b = b + ((a * p5) << 1);
            b = sra(b, 2) + (p4 << 16);
            a = sra(sra(q * q, 13) * (p3 << 5), 3) + sra(p2 * a, 1);
            a = sra(a, 18);
            dv = sra((32'd32768 + a) * p1, 15);
            pc = 32'd1048576 - 32'(r.raw_pressure);
            pc = (pc - sra(b, 12)) * 32'd3125;
            if (dv == 0) begin
                pc = 0;
                res.divide_fault = 1'b1;
            end else begin
                if (pc[31]) pc = (pc / dv) << 1;
                else pc = (pc << 1) / dv;
                q = sra(pc, 3);
                a = sra(p9 * sra(q * q, 13), 12);
                b = sra(sra(pc, 2) * p8, 13);
                q = sra(pc, 8);
                c = sra(q * q * q * p10, 17);
                pc = pc + sra(a + b + c + (p7 << 7), 4);
            end

            v1 = 32'(r.raw_humidity) - (h1 << 4) - sra(div100(temp * h3), 1);
            v2 = sra(h2 * (div100(temp * h4) + div100(sra(temp * div100(temp * h5), 6))
                 + 32'd16384), 10);
            v3 = v1 * v2;
            v4 = sra((h6 << 7) + div100(temp * h7), 4);
            q = sra(v3, 14);
            v5 = sra(q * q, 10);
            v6 = sra(v4 * v5, 1);
            hum = sra(sra(v3 + v6, 10) * 32'd1000, 12);
            if (hum[31]) hum = 0;
            else if (hum > 32'd102400) hum = 32'd102400;

            res.temperature_centi = temp;
            res.pressure_pa = pc;
            res.humidity_q10 = hum[16:0];
            return res;
        endfunction

        function void note_request(esc_pkg::t_req r);
            pending.push_back(compensate(r));
        endfunction

        function void check_result(esc_pkg::t_res got);
            esc_pkg::t_res exp_res;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_res = pending.pop_front();
            if (got !== exp_res) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: temp %0d/%0d pres %0d/%0d hum %0d/%0d fault %b/%b",
                             exp_res.temperature_centi, got.temperature_centi,
                             exp_res.pressure_pa, got.pressure_pa,
                             exp_res.humidity_q10, got.humidity_q10,
                             exp_res.divide_fault, got.divide_fault);
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    esc_pkg::t_req i_req = '0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = '0;
    logic [63:0]   i_cfg_data = '0;
    logic          o_valid;
    esc_pkg::t_res o_res;

    compensation_scoreboard sb = new();

    env_sensor_compensation_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Results are sampled at the edge that ends their cycle.
    always @(posedge i_clk)
        if (i_rst_n && o_valid) sb.check_result(o_res);

    // Drive a register write, then deassert the write enable and let the bus idle.
    task automatic write_reg(esc_pkg::t_cfg_idx idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_calib(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one request and hold it until accepted, then insert a random gap.
    task automatic send_request(esc_pkg::t_req r);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (esc_pkg::LAT + 10) @(posedge i_clk);
    endtask

    function automatic esc_pkg::t_req rand_req();
        esc_pkg::t_req r;
        r.raw_temperature = 20'($urandom);
        r.raw_pressure    = 20'($urandom);
        r.raw_humidity    = 16'($urandom);
        return r;
    endfunction

    // Plausible calibration set with random perturbation.
    task automatic typical_calib();
        write_reg(esc_pkg::CFG_TEMP, {8'($urandom_range(0, 6) + 1),
                                      16'(26000 + $urandom_range(0, 1000)),
                                      16'(26000 + $urandom_range(0, 1000))});
        write_reg(esc_pkg::CFG_PRES_A, {16'(2000 + $urandom_range(0, 2000)), 8'd88,
                                        16'($signed(-10000) - $urandom_range(0, 500)),
                                        16'(36000 + $urandom_range(0, 1000))});
        write_reg(esc_pkg::CFG_PRES_B, {16'($signed(-100) - $urandom_range(0, 300)), 8'd64,
                                        8'd30, 16'($signed(-100) + $urandom_range(0, 50))});
        write_reg(esc_pkg::CFG_PRES_C, {8'd30, 16'(3000 + $urandom_range(0, 500))});
        write_reg(esc_pkg::CFG_HUM, {8'd45, 8'd120, 8'($urandom_range(0, 30)), 8'd45, 8'd0,
                                     12'(1000 + $urandom_range(0, 200)),
                                     12'(700 + $urandom_range(0, 100))});
    endtask

    task automatic random_calib();
        for (int i = 0; i < 5; i++)
            write_reg(esc_pkg::t_cfg_idx'(i), {$urandom, $urandom});
    endtask

    initial begin
        esc_pkg::t_req r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset calibration gives a zero divisor.
        send_request('0);
        send_request('1);
        drain();
        typical_calib();
        send_request('0);
        send_request('1);
        send_request('{20'd500000, 20'd300000, 16'd25000});
        send_request('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_request('{20'd0, 20'hFFFFF, 16'd0});
        send_request('{20'd520000, 20'd350000, 16'd30000});
        drain();
        // Extreme calibration: all ones, then signed fields at minimum, most unsigned at maximum.
        for (int i = 0; i < 5; i++) write_reg(esc_pkg::t_cfg_idx'(i), '1);
        send_request('0);
        send_request('1);
        send_request('{20'h80000, 20'h80000, 16'h8000});
        drain();
        write_reg(esc_pkg::CFG_TEMP, 64'h80_8000_0000);
        write_reg(esc_pkg::CFG_PRES_A, 64'h80_0080_8000_FFFF);
        write_reg(esc_pkg::CFG_PRES_B, 64'h8000_8080_8000);
        write_reg(esc_pkg::CFG_PRES_C, 64'hFF_8000);
        write_reg(esc_pkg::CFG_HUM, 64'hFFFF_8080_80FF_FFFF);
        send_request('0);
        send_request('1);
        send_request('{20'd400000, 20'd900000, 16'd40000});
        drain();

        // Random phases: mostly plausible calibration, some fully random.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 2) random_calib();
            else typical_calib();
            for (int n = 0; n < 82; n++) begin
                r = rand_req();
                if (ph % 3 != 2 && $urandom_range(0, 3) != 0) begin
                    r.raw_temperature = 20'(480000 + $urandom_range(0, 80000));
                    r.raw_pressure    = 20'(250000 + $urandom_range(0, 200000));
                end
                send_request(r);
            end
            drain();
        end

        if (sb.mismatches == 0) $display("env_sensor_compensation_unit test passed");
        else $display("env_sensor_compensation_unit test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("env_sensor_compensation_unit test failed");
        $finish;
    end
endmodule
